>>> rtl/core/isu_pkg.sv
// Package for the insertion sorter: state encoding and the control bundle
// broadcast from the top level to every cell of the sorting chain.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package isu_pkg;

    // Width of one sorted element.
    localparam int unsigned DATA_W = 32;

    // Controller states: collecting a batch, or draining the sorted batch.
    typedef enum logic [0:0] {
        ST_FILL = 1'b0,
        ST_EMIT = 1'b1
    } isu_state_t;

    // Command broadcast to all cells at once.
    typedef struct packed {
        logic                     insert;  // place din into the chain
        logic                     shift;   // move every cell one place to the front
        logic signed [DATA_W-1:0] din;     // value being inserted
    } isu_cell_ctrl_t;

endpackage : isu_pkg

`default_nettype wire

>>> rtl/core/isu_cell.sv
// One cell of the insertion chain: holds one element and its valid bit.
// Depends on isu_pkg for the control bundle and data width.
`timescale 1ns / 1ps
`default_nettype none

module isu_cell
    import isu_pkg::*;
(
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire isu_cell_ctrl_t           ctrl,
    // Neighbour towards the front (smaller values)
    input  wire logic signed [DATA_W-1:0] left_value,
    input  wire logic                     left_valid,
    input  wire logic                     left_gt,
    // Neighbour towards the back (larger values)
    input  wire logic signed [DATA_W-1:0] right_value,
    input  wire logic                     right_valid,
    // Own contents
    output logic signed [DATA_W-1:0]      value,
    output logic                          valid,
    output logic                          gt
);

    logic signed [DATA_W-1:0] value_reg, value_next;
    logic                     valid_reg, valid_next;

    // Strictly greater, so an equal new value settles behind older ones.
    assign gt = valid_reg && (value_reg > ctrl.din);

    // Next contents: take the front neighbour when it is pushed back, take the
    // new value where it lands, or move forward while the batch drains.
    always_comb begin
        value_next = value_reg;
        valid_next = valid_reg;
        if (ctrl.insert) begin
            if (left_gt) begin
                value_next = left_value;
            end else if (gt || (!valid_reg && left_valid)) begin
                value_next = ctrl.din;
            end
            valid_next = valid_reg || left_valid;
        end else if (ctrl.shift) begin
            value_next = right_value;
            valid_next = right_valid;
        end
    end

    // Valid bit is control state; the element itself needs no reset.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        value_reg <= value_next;
    end

    assign value = value_reg;
    assign valid = valid_reg;

endmodule : isu_cell

`default_nettype wire

>>> rtl/core/insertion_sorter_unit.sv
// Top level of the insertion sorter: a chain of isu_cell instances and the
// fill/drain controller. Depends on isu_pkg and isu_cell.
//
//  Channel   Direction  Signals                    Contents
//  s_        in         tvalid tready tdata tlast  tdata[31:0] value, tlast last
//  m_        out        tvalid tready tdata tlast  tdata[31:0] sorted_value,
//                       tuser                      tlast last_out, tuser overflow
//
// While a batch is collected one input transaction is taken every cycle; the
// value is broadcast to all cells of the chain at once and lands in its place
// in that same cycle; once the chain is full, values are dropped and mark
// overflow. The transaction marked last starts the drain: one result per
// stored element, one per cycle while m_tready is high, taken from the front
// cell while the chain moves forward; s_tready stays low throughout the drain.
// aresetn is synchronous and active low; it empties the chain (no sweep).
// A low m_tready simply holds the front cell and the whole chain.
`timescale 1ns / 1ps
`default_nettype none

module insertion_sorter_unit
    import isu_pkg::*;
#(
    parameter int unsigned MAX_ITEMS = 16
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // Input stream
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,   // [31:0] value
    input  wire logic        s_tlast,   // last
    // Result stream
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata,   // [31:0] sorted_value
    output logic             m_tlast,   // last_out
    output logic             m_tuser    // [0] overflow
);

    isu_state_t     state_reg, state_next;
    logic           dropped_reg, dropped_next;
    isu_cell_ctrl_t ctrl;

    logic signed [DATA_W-1:0] cell_value [MAX_ITEMS];
    logic [MAX_ITEMS-1:0]     cell_valid;
    logic [MAX_ITEMS-1:0]     cell_gt;

    logic full;

    assign full = cell_valid[MAX_ITEMS-1];

    // Controller: next state, cell commands and the overflow mark.
    // s_tready is high throughout ST_FILL and m_tvalid throughout ST_EMIT, so
    // the other side of each handshake alone decides the transfer there.
    always_comb begin
        state_next   = state_reg;
        dropped_next = dropped_reg;
        s_tready     = 1'b0;
        m_tvalid     = 1'b0;
        ctrl.insert  = 1'b0;
        ctrl.shift   = 1'b0;
        ctrl.din     = $signed(s_tdata);
        case (state_reg)
            ST_FILL: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    if (full) begin
                        dropped_next = 1'b1;
                    end else begin
                        ctrl.insert = 1'b1;
                    end
                    if (s_tlast) begin
                        state_next = ST_EMIT;
                    end
                end
            end
            ST_EMIT: begin
                m_tvalid = 1'b1;
                if (m_tready) begin
                    ctrl.shift = 1'b1;
                    if (!cell_valid[1]) begin
                        state_next   = ST_FILL;
                        dropped_next = 1'b0;
                    end
                end
            end
            default: begin
                state_next = ST_FILL;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_FILL;
            dropped_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            dropped_reg <= dropped_next;
        end
    end

    // The sorting chain; cell 0 holds the smallest element.
    for (genvar i = 0; i < MAX_ITEMS; i++) begin : g_cell
        logic signed [DATA_W-1:0] l_value;
        logic                     l_valid;
        logic                     l_gt;
        logic signed [DATA_W-1:0] r_value;
        logic                     r_valid;

        // The front end sees an always-present neighbour that never moves back.
        if (i == 0) begin : g_front
            assign l_value = '0;
            assign l_valid = 1'b1;
            assign l_gt    = 1'b0;
        end else begin : g_inner_l
            assign l_value = cell_value[i-1];
            assign l_valid = cell_valid[i-1];
            assign l_gt    = cell_gt[i-1];
        end

        // The back end drains in empty slots.
        if (i == MAX_ITEMS - 1) begin : g_back
            assign r_value = '0;
            assign r_valid = 1'b0;
        end else begin : g_inner_r
            assign r_value = cell_value[i+1];
            assign r_valid = cell_valid[i+1];
        end

        isu_cell u_cell (
            .aclk        (aclk),
            .aresetn     (aresetn),
            .ctrl        (ctrl),
            .left_value  (l_value),
            .left_valid  (l_valid),
            .left_gt     (l_gt),
            .right_value (r_value),
            .right_valid (r_valid),
            .value       (cell_value[i]),
            .valid       (cell_valid[i]),
            .gt          (cell_gt[i])
        );
    end

    // Results come straight from the front cell's registers.
    assign m_tdata = cell_value[0];
    assign m_tlast = !cell_valid[1];
    assign m_tuser = dropped_reg;

endmodule : insertion_sorter_unit

`default_nettype wire

>>> rtl/core/isu_checker.sv
// Port-level checker for insertion_sorter_unit, attached by the bind below.
// Depends only on the top level's ports.
`timescale 1ns / 1ps
`default_nettype none

module isu_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic        s_tlast,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [31:0] m_tdata,
    input wire logic        m_tlast,
    input wire logic        m_tuser
);

    // Collecting and draining never overlap.
    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_tready && m_tvalid))
        else $error("input accepted while results are pending");

    // A transaction closing a batch starts the drain in the next cycle.
    a_drain_starts: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && s_tlast) |=> m_tvalid)
        else $error("batch end did not start the result stream");

    // After the final result the block is ready for a new batch.
    a_back_to_fill: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tready && m_tlast) |=> (s_tready && !m_tvalid))
        else $error("block did not return to collecting after the final result");

    // A stalled result holds its contents.
    a_out_stable: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=>
            (m_tvalid && $stable(m_tdata) && $stable(m_tlast) && $stable(m_tuser)))
        else $error("stalled result changed");

endmodule : isu_checker

bind insertion_sorter_unit isu_checker u_isu_checker (.*);

`default_nettype wire
